### rtl/modexp_pkg.sv
package modexp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NEXT,
    ST_DBL,
    ST_ADD,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture operands, start base reduction
    logic red_step;  // one restoring step of base mod m
    logic mul_init;  // start both products (pm*b and b*b)
    logic dbl_step;  // acc = 2*acc mod m
    logic add_step;  // acc = acc + operand mod m, if multiplier bit set
    logic mul_done;  // commit b*b, pm*b if e[0]; shift exponent
    logic out_load;  // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_last;
    logic e_zero;
  } status_t;

endpackage

### rtl/modular_exponentiation_core.sv
// Channel  Handshake            Payload
// cfg      cfg_valid/cfg_ready  modulus
// in       in_valid/in_ready    base, exponent
// out      out_valid/out_ready  power_mod
//
// One item at a time. Base reduction runs first, then each exponent bit up to
// the top set bit gets a square and a multiply (run side by side on a bit-serial
// add-and-double unit); a zero exponent goes from reduction straight to finish.
// Synchronous reset; modulus resets to 2. A waiting result does not block
// the next beat in; only the final write to the output register waits.
module modular_exponentiation_core #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [WORD_BITS-1:0] modulus,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] base,
  input  logic [WORD_BITS-1:0] exponent,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] power_mod
);

  modexp_pkg::cmd_t    cmd;
  modexp_pkg::status_t status;

  assign cfg_ready = 1'b1;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  modexp_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .modulus   (modulus),
    .base      (base),
    .exponent  (exponent),
    .cmd       (cmd),
    .status    (status),
    .power_mod (power_mod)
  );

endmodule

### rtl/modexp_datapath.sv
module modexp_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr,
  input  logic [WORD_BITS-1:0] modulus,
  input  logic [WORD_BITS-1:0] base,
  input  logic [WORD_BITS-1:0] exponent,
  input  modexp_pkg::cmd_t     cmd,
  output modexp_pkg::status_t  status,
  output logic [WORD_BITS-1:0] power_mod
);

  localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(WORD_BITS - 1);

  logic [WORD_BITS-1:0] mod_reg;
  logic [WORD_BITS:0]   m_ext;     // modulus 0 stands for 2^WORD_BITS
  logic [WORD_BITS-1:0] b;         // reduced base power
  logic [WORD_BITS-1:0] pm;        // running result
  logic [WORD_BITS-1:0] e;
  logic [WORD_BITS-1:0] sh;        // multiplier bits, MSB first
  logic [WORD_BITS-1:0] acc_p;     // pm * b
  logic [WORD_BITS-1:0] acc_s;     // b * b
  logic [CNT_W-1:0]     cnt;
  logic [WORD_BITS:0]   red_sum;
  logic [WORD_BITS-1:0] red_next;

  // (a + c) mod m for a, c < m
  function automatic logic [WORD_BITS-1:0] add_mod(
    input logic [WORD_BITS-1:0] a,
    input logic [WORD_BITS-1:0] c,
    input logic [WORD_BITS:0]   m
  );
    logic [WORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, c};
    if (s >= m) begin
      s = s - m;
    end
    return s[WORD_BITS-1:0];
  endfunction

  assign m_ext = {(mod_reg == '0), mod_reg};

  always_comb begin
    red_sum = {b, sh[WORD_BITS-1]};
    if (red_sum >= m_ext) begin
      red_sum = red_sum - m_ext;
    end
    red_next = red_sum[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_reg <= WORD_BITS'(2);
    end else if (cfg_wr) begin
      mod_reg <= modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sh  <= base;
      e   <= exponent;
      b   <= '0;
      cnt <= CNT_TOP;
      // modulus one with a nonzero exponent gives 0; everything else starts at 1
      pm  <= (m_ext == (WORD_BITS+1)'(1) && exponent != '0) ? '0 : WORD_BITS'(1);
    end
    if (cmd.red_step) begin
      b   <= red_next;
      sh  <= {sh[WORD_BITS-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.mul_init) begin
      sh    <= b;
      acc_p <= '0;
      acc_s <= '0;
      cnt   <= CNT_TOP;
    end
    if (cmd.dbl_step) begin
      acc_p <= add_mod(acc_p, acc_p, m_ext);
      acc_s <= add_mod(acc_s, acc_s, m_ext);
    end
    if (cmd.add_step) begin
      if (sh[WORD_BITS-1]) begin
        acc_p <= add_mod(acc_p, pm, m_ext);
        acc_s <= add_mod(acc_s, b, m_ext);
      end
      sh  <= {sh[WORD_BITS-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.mul_done) begin
      if (e[0]) begin
        pm <= acc_p;
      end
      b <= acc_s;
      e <= {1'b0, e[WORD_BITS-1:1]};
    end
    if (cmd.out_load) begin
      power_mod <= pm;
    end
  end

  assign status.cnt_last = (cnt == '0);
  assign status.e_zero   = (e == '0);

endmodule

### rtl/modexp_ctrl.sv
module modexp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  modexp_pkg::status_t status,
  output modexp_pkg::cmd_t    cmd
);

  modexp_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      modexp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = modexp_pkg::ST_REDUCE;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        cmd.red_step = 1'b1;
        if (status.cnt_last) begin
          state_next = modexp_pkg::ST_NEXT;
        end
      end
      modexp_pkg::ST_NEXT: begin
        if (status.e_zero) begin
          state_next = modexp_pkg::ST_FINISH;
        end else begin
          cmd.mul_init = 1'b1;
          state_next   = modexp_pkg::ST_DBL;
        end
      end
      modexp_pkg::ST_DBL: begin
        cmd.dbl_step = 1'b1;
        state_next   = modexp_pkg::ST_ADD;
      end
      modexp_pkg::ST_ADD: begin
        cmd.add_step = 1'b1;
        state_next   = status.cnt_last ? modexp_pkg::ST_UPDATE : modexp_pkg::ST_DBL;
      end
      modexp_pkg::ST_UPDATE: begin
        cmd.mul_done = 1'b1;
        state_next   = modexp_pkg::ST_NEXT;
      end
      modexp_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = modexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = modexp_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == modexp_pkg::ST_REDUCE)
    else $error("accepted beat did not start base reduction");

  a_mul_ends: assert property (@(posedge clk) disable iff (rst)
    state == modexp_pkg::ST_ADD && status.cnt_last |=> state == modexp_pkg::ST_UPDATE)
    else $error("product loop overran its bit count");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == modexp_pkg::ST_FINISH)
    else $error("result beat raised outside finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("pending result beat overwritten");

endmodule
